// ----- rtl/core/hbp_pkg.sv -----
// ---------------------------------------------------------------------------
// hbp_pkg
// Shared types, constants and helper functions for the hybrid branch
// predictor.
// ---------------------------------------------------------------------------
package hbp_pkg;

    localparam int BIMODAL_BITS_MAX_DEF = 14;
    localparam int GSHARE_BITS_MAX_DEF  = 14;
    localparam int CHOOSER_BITS_MAX_DEF = 14;

    localparam int HIST_W  = 14;
    localparam int PC_W    = 32;
    localparam int WORD_W  = PC_W - 2;
    localparam int COUNT_W = 32;
    localparam int CTR_W   = 2;
    localparam int BITS_W  = 5;
    localparam int MASK_W  = 32;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] MODE_BIMODAL = 2'd0;
    localparam logic [1:0] MODE_GSHARE  = 2'd1;
    localparam logic [1:0] MODE_HYBRID  = 2'd2;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_BIMODAL = 3'd1;
    localparam logic [2:0] REG_GSHARE  = 3'd2;
    localparam logic [2:0] REG_HISTORY = 3'd3;
    localparam logic [2:0] REG_CHOOSER = 3'd4;

    localparam logic [1:0] RST_MODE    = MODE_HYBRID;
    localparam logic [3:0] RST_BIMODAL = 4'd12;
    localparam logic [3:0] RST_GSHARE  = 4'd12;
    localparam logic [3:0] RST_HISTORY = 4'd8;
    localparam logic [3:0] RST_CHOOSER = 4'd10;

    localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [CTR_W-1:0] CTR_CHOOSER_RST = 2'd1;
    localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;

    typedef struct packed {
        logic [1:0] predictor_mode;
        logic [3:0] bimodal_bits;
        logic [3:0] gshare_bits;
        logic [3:0] history_bits;
        logic [3:0] chooser_bits;
    } cfg_t;

    function automatic logic [MASK_W-1:0] low_mask(input logic [BITS_W-1:0] n);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            m[i] = (BITS_W'(i) < n);
        end
        return m;
    endfunction

    function automatic logic [BITS_W-1:0] clamp_bits(input logic [3:0] v,
                                                     input logic [BITS_W-1:0] maxv);
        logic [BITS_W-1:0] ve;
        ve = BITS_W'(v);
        return (ve > maxv) ? maxv : ve;
    endfunction

    function automatic logic [CTR_W-1:0] train(input logic [CTR_W-1:0] c,
                                               input logic t);
        logic [CTR_W-1:0] r;
        if (t)
        begin
            r = (c < CTR_MAX) ? c + 2'd1 : CTR_MAX;
        end
        else
        begin
            r = (c > 2'd0) ? c - 2'd1 : 2'd0;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/hbp_if.sv -----
// ---------------------------------------------------------------------------
// hbp_if
// Valid/ready channels: resolved branch in, prediction result out.
// ---------------------------------------------------------------------------
interface hbp_branch_if;
    logic                     valid;
    logic                     ready;
    logic [hbp_pkg::PC_W-1:0] branch_pc;
    logic                     taken;

    modport source (output valid, output branch_pc, output taken, input ready);
    modport sink   (input valid, input branch_pc, input taken, output ready);
endinterface

interface hbp_result_if;
    logic                        valid;
    logic                        ready;
    logic                        predicted_taken;
    logic                        mispredicted;
    logic [hbp_pkg::COUNT_W-1:0] prediction_count;
    logic [hbp_pkg::COUNT_W-1:0] mispredict_count;

    modport source (output valid, output predicted_taken, output mispredicted,
                    output prediction_count, output mispredict_count, input ready);
    modport sink   (input valid, input predicted_taken, input mispredicted,
                    input prediction_count, input mispredict_count, output ready);
endinterface

// ----- rtl/core/hbp_cfg.sv -----
// ---------------------------------------------------------------------------
// hbp_cfg
// APB register block holding the predictor configuration.
// ---------------------------------------------------------------------------
module hbp_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hbp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [hbp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [hbp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output hbp_pkg::cfg_t                      cfg
);

    hbp_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[hbp_pkg::APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.predictor_mode <= hbp_pkg::RST_MODE;
            cfg_reg.bimodal_bits   <= hbp_pkg::RST_BIMODAL;
            cfg_reg.gshare_bits    <= hbp_pkg::RST_GSHARE;
            cfg_reg.history_bits   <= hbp_pkg::RST_HISTORY;
            cfg_reg.chooser_bits   <= hbp_pkg::RST_CHOOSER;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                hbp_pkg::REG_MODE:    cfg_reg.predictor_mode <= pwdata[1:0];
                hbp_pkg::REG_BIMODAL: cfg_reg.bimodal_bits   <= pwdata[3:0];
                hbp_pkg::REG_GSHARE:  cfg_reg.gshare_bits    <= pwdata[3:0];
                hbp_pkg::REG_HISTORY: cfg_reg.history_bits   <= pwdata[3:0];
                hbp_pkg::REG_CHOOSER: cfg_reg.chooser_bits   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            hbp_pkg::REG_MODE:    prdata = 32'(cfg_reg.predictor_mode);
            hbp_pkg::REG_BIMODAL: prdata = 32'(cfg_reg.bimodal_bits);
            hbp_pkg::REG_GSHARE:  prdata = 32'(cfg_reg.gshare_bits);
            hbp_pkg::REG_HISTORY: prdata = 32'(cfg_reg.history_bits);
            hbp_pkg::REG_CHOOSER: prdata = 32'(cfg_reg.chooser_bits);
            default:              prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/hbp_index.sv -----
// ---------------------------------------------------------------------------
// hbp_index
// Global history register and table index generation for one branch.
// ---------------------------------------------------------------------------
module hbp_index
#(
    parameter int BIMODAL_BITS_MAX = hbp_pkg::BIMODAL_BITS_MAX_DEF,
    parameter int GSHARE_BITS_MAX  = hbp_pkg::GSHARE_BITS_MAX_DEF,
    parameter int CHOOSER_BITS_MAX = hbp_pkg::CHOOSER_BITS_MAX_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  hbp_pkg::cfg_t                 cfg,
    input  logic [hbp_pkg::PC_W-1:0]      branch_pc,
    input  logic                          taken,
    input  logic                          advance,
    output logic [BIMODAL_BITS_MAX-1:0]   bi,
    output logic [GSHARE_BITS_MAX-1:0]    gi,
    output logic [CHOOSER_BITS_MAX-1:0]   ci
);

    localparam int BW = hbp_pkg::BITS_W;
    localparam int HW = hbp_pkg::HIST_W;

    logic [HW-1:0]                 ghist_reg;
    logic [HW-1:0]                 ghist_next;
    logic [hbp_pkg::WORD_W-1:0]    word;
    logic [BW-1:0]                 m2;
    logic [BW-1:0]                 m1;
    logic [BW-1:0]                 k;
    logic [BW-1:0]                 n;
    logic [BW-1:0]                 lowlen;
    logic [hbp_pkg::MASK_W-1:0]    mask_b;
    logic [hbp_pkg::MASK_W-1:0]    mask_g;
    logic [hbp_pkg::MASK_W-1:0]    mask_c;
    logic [hbp_pkg::MASK_W-1:0]    mask_n;
    logic [hbp_pkg::MASK_W-1:0]    hist_sh;
    logic [hbp_pkg::MASK_W-1:0]    tbit;
    logic [GSHARE_BITS_MAX-1:0]    pcm;
    logic [HW-1:0]                 hist_m;

    assign word   = branch_pc[hbp_pkg::PC_W-1:2];
    assign m2     = hbp_pkg::clamp_bits(cfg.bimodal_bits, BW'(BIMODAL_BITS_MAX));
    assign m1     = hbp_pkg::clamp_bits(cfg.gshare_bits, BW'(GSHARE_BITS_MAX));
    assign k      = hbp_pkg::clamp_bits(cfg.chooser_bits, BW'(CHOOSER_BITS_MAX));
    assign n      = (BW'(cfg.history_bits) > m1) ? m1 : BW'(cfg.history_bits);
    assign lowlen = m1 - n;

    assign mask_b = hbp_pkg::low_mask(m2);
    assign mask_g = hbp_pkg::low_mask(m1);
    assign mask_c = hbp_pkg::low_mask(k);
    assign mask_n = hbp_pkg::low_mask(n);

    assign bi = word[BIMODAL_BITS_MAX-1:0] & mask_b[BIMODAL_BITS_MAX-1:0];
    assign ci = word[CHOOSER_BITS_MAX-1:0] & mask_c[CHOOSER_BITS_MAX-1:0];

    // history folds into the upper n bits of the gshare index
    assign pcm     = word[GSHARE_BITS_MAX-1:0] & mask_g[GSHARE_BITS_MAX-1:0];
    assign hist_m  = ghist_reg & mask_n[HW-1:0];
    assign hist_sh = hbp_pkg::MASK_W'(hist_m) << lowlen;
    assign gi      = pcm ^ hist_sh[GSHARE_BITS_MAX-1:0];

    assign tbit = hbp_pkg::MASK_W'(taken) << (n - BW'(1));

    always_comb
    begin
        if (n == '0)
        begin
            ghist_next = '0;
        end
        else
        begin
            ghist_next = {1'b0, ghist_reg[HW-1:1]} | tbit[HW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ghist_reg <= '0;
        end
        else if (advance)
        begin
            ghist_reg <= ghist_next;
        end
    end

endmodule

// ----- rtl/core/hbp_table.sv -----
// ---------------------------------------------------------------------------
// hbp_table
// 2-bit counter table: single-port write, registered read with bypass of
// a write landing on the same edge, and a clearing sweep after reset.
// ---------------------------------------------------------------------------
module hbp_table
#(
    parameter int               ADDR_W    = hbp_pkg::BIMODAL_BITS_MAX_DEF,
    parameter logic [1:0]       RESET_VAL = hbp_pkg::CTR_WEAK_TAKEN
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [hbp_pkg::CTR_W-1:0]  rd_data,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [hbp_pkg::CTR_W-1:0]  wr_data,
    output logic                       busy
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [hbp_pkg::CTR_W-1:0] mem [DEPTH];
    logic [hbp_pkg::CTR_W-1:0] mem_q_reg;
    logic [hbp_pkg::CTR_W-1:0] fwd_data_reg;
    logic                      fwd_hit_reg;
    logic                      busy_reg;
    logic [ADDR_W-1:0]         clr_cnt_reg;
    logic                      we;
    logic [ADDR_W-1:0]         wa;
    logic [hbp_pkg::CTR_W-1:0] wd;

    assign busy    = busy_reg;
    assign we      = busy_reg || wr_en;
    assign wa      = busy_reg ? clr_cnt_reg : wr_addr;
    assign wd      = busy_reg ? RESET_VAL : wr_data;
    assign rd_data = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (rd_en)
            begin
                fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

endmodule

// ----- rtl/core/hybrid_branch_predictor.sv -----
// ---------------------------------------------------------------------------
// hybrid_branch_predictor
// Tournament predictor: bimodal and gshare counter tables with a chooser.
// ---------------------------------------------------------------------------
// A branch moves through the s1 register, the registered table reads with the s2
// register, and the output register. Throughput: one branch per cycle while the
// result channel is not stalled; table reads are registered and the write-back of
// the previous branch is bypassed into the next one.
// Reset: tables are swept to their reset values, one entry per cycle; no branch is
// accepted until the sweep ends.
module hybrid_branch_predictor
#(
    parameter int BIMODAL_BITS_MAX = hbp_pkg::BIMODAL_BITS_MAX_DEF,
    parameter int GSHARE_BITS_MAX  = hbp_pkg::GSHARE_BITS_MAX_DEF,
    parameter int CHOOSER_BITS_MAX = hbp_pkg::CHOOSER_BITS_MAX_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    hbp_branch_if.sink                     branch_in,
    hbp_result_if.source                   result_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hbp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hbp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hbp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int CW = hbp_pkg::CTR_W;

    hbp_pkg::cfg_t cfg;

    logic                        s1_valid_reg;
    logic [hbp_pkg::PC_W-1:0]    s1_pc_reg;
    logic                        s1_taken_reg;
    logic                        s2_valid_reg;
    logic                        s2_taken_reg;
    logic [BIMODAL_BITS_MAX-1:0] s2_bi_reg;
    logic [GSHARE_BITS_MAX-1:0]  s2_gi_reg;
    logic [CHOOSER_BITS_MAX-1:0] s2_ci_reg;

    logic                        out_valid_reg;
    logic                        out_pred_reg;
    logic                        out_mis_reg;
    logic [hbp_pkg::COUNT_W-1:0] out_pcount_reg;
    logic [hbp_pkg::COUNT_W-1:0] out_mcount_reg;
    logic [hbp_pkg::COUNT_W-1:0] pred_total_reg;
    logic [hbp_pkg::COUNT_W-1:0] pred_total_next;
    logic [hbp_pkg::COUNT_W-1:0] mis_total_reg;
    logic [hbp_pkg::COUNT_W-1:0] mis_total_next;

    logic                        accept;
    logic                        s1_adv;
    logic                        s2_fire;
    logic                        busy_b;
    logic                        busy_g;
    logic                        busy_c;

    logic [BIMODAL_BITS_MAX-1:0] bi;
    logic [GSHARE_BITS_MAX-1:0]  gi;
    logic [CHOOSER_BITS_MAX-1:0] ci;
    logic [CW-1:0]               b_ctr;
    logic [CW-1:0]               g_ctr;
    logic [CW-1:0]               c_ctr;
    logic [CW-1:0]               c_new;

    logic                        bpred;
    logic                        gpred;
    logic                        use_g;
    logic                        hybrid;
    logic                        pred;
    logic                        mis;

    hbp_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s2_fire = s2_valid_reg && (!out_valid_reg || result_out.ready);
    assign s1_adv  = s1_valid_reg && (!s2_valid_reg || s2_fire);
    assign branch_in.ready = !(busy_b || busy_g || busy_c) && (!s1_valid_reg || s1_adv);
    assign accept  = branch_in.valid && branch_in.ready;

    hbp_index
    #(
        .BIMODAL_BITS_MAX (BIMODAL_BITS_MAX),
        .GSHARE_BITS_MAX  (GSHARE_BITS_MAX),
        .CHOOSER_BITS_MAX (CHOOSER_BITS_MAX)
    )
    u_index
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .branch_pc (s1_pc_reg),
        .taken     (s1_taken_reg),
        .advance   (s1_adv),
        .bi        (bi),
        .gi        (gi),
        .ci        (ci)
    );

    // stage 2: predict and train
    assign bpred  = b_ctr[1];
    assign gpred  = g_ctr[1];
    assign hybrid = (cfg.predictor_mode != hbp_pkg::MODE_BIMODAL) &&
                    (cfg.predictor_mode != hbp_pkg::MODE_GSHARE);
    assign use_g  = (cfg.predictor_mode == hbp_pkg::MODE_GSHARE) || (hybrid && c_ctr[1]);
    assign pred   = use_g ? gpred : bpred;
    assign mis    = pred != s2_taken_reg;

    always_comb
    begin
        c_new = c_ctr;
        if ((gpred == s2_taken_reg) != (bpred == s2_taken_reg))
        begin
            c_new = hbp_pkg::train(c_ctr, gpred == s2_taken_reg);
        end
    end

    assign pred_total_next = pred_total_reg + hbp_pkg::COUNT_W'(1);
    assign mis_total_next  = mis_total_reg + hbp_pkg::COUNT_W'(mis);

    hbp_table #(.ADDR_W(BIMODAL_BITS_MAX), .RESET_VAL(hbp_pkg::CTR_WEAK_TAKEN)) u_bimodal
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s1_adv),
        .rd_addr (bi),
        .rd_data (b_ctr),
        .wr_en   (s2_fire && !use_g),
        .wr_addr (s2_bi_reg),
        .wr_data (hbp_pkg::train(b_ctr, s2_taken_reg)),
        .busy    (busy_b)
    );

    hbp_table #(.ADDR_W(GSHARE_BITS_MAX), .RESET_VAL(hbp_pkg::CTR_WEAK_TAKEN)) u_gshare
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s1_adv),
        .rd_addr (gi),
        .rd_data (g_ctr),
        .wr_en   (s2_fire && use_g),
        .wr_addr (s2_gi_reg),
        .wr_data (hbp_pkg::train(g_ctr, s2_taken_reg)),
        .busy    (busy_g)
    );

    hbp_table #(.ADDR_W(CHOOSER_BITS_MAX), .RESET_VAL(hbp_pkg::CTR_CHOOSER_RST)) u_chooser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s1_adv),
        .rd_addr (ci),
        .rd_data (c_ctr),
        .wr_en   (s2_fire && hybrid),
        .wr_addr (s2_ci_reg),
        .wr_data (c_new),
        .busy    (busy_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pred_total_reg <= '0;
            mis_total_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_fire)
            begin
                out_valid_reg  <= 1'b1;
                pred_total_reg <= pred_total_next;
                mis_total_reg  <= mis_total_next;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pc_reg    <= branch_in.branch_pc;
            s1_taken_reg <= branch_in.taken;
        end
        if (s1_adv)
        begin
            s2_taken_reg <= s1_taken_reg;
            s2_bi_reg    <= bi;
            s2_gi_reg    <= gi;
            s2_ci_reg    <= ci;
        end
        if (s2_fire)
        begin
            out_pred_reg   <= pred;
            out_mis_reg    <= mis;
            out_pcount_reg <= pred_total_next;
            out_mcount_reg <= mis_total_next;
        end
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.predicted_taken  = out_pred_reg;
    assign result_out.mispredicted     = out_mis_reg;
    assign result_out.prediction_count = out_pcount_reg;
    assign result_out.mispredict_count = out_mcount_reg;

endmodule
